@@ rtl/pcts_pkg.sv @@
// Package for the pixel class triangle scorer: constants, field types and the
// front-to-back queue entry. No dependencies.
package pcts_pkg;
  localparam int NUM_TRIANGLES = 11;
  localparam int COORD_BITS = 10;
  localparam int TABLE_INDEX_BITS = 8;
  localparam int TRI_SPACING = 58;
  localparam int TRI_HEIGHT = 430;
  localparam int TRI_IDX_BITS = 4;
  localparam int SUM_BITS = 32;
  localparam int POS_BITS = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = 2;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIRST_ROW = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  // One classified pixel handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]            value;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] half;
    logic                  active;
    logic                  frame_end;
  } pix_t;
endpackage

@@ rtl/pcts_front.sv @@
// Front part: class table memory, raster counters and the per-row half-width.
// Depends on pcts_pkg.
module pcts_front import pcts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  opcode,
  input  logic [7:0]            hue,
  input  logic [7:0]            saturation,
  input  logic [7:0]            table_value,
  input  logic [10:0]           width_cfg,
  input  logic [10:0]           height_cfg,
  input  logic [9:0]            first_row_cfg,
  output logic                  pix_valid,
  output pix_t                  pix
);
  logic [7:0] mem [0:65535];
  logic [7:0] rd_r;
  logic        zero_r;
  logic        valid_r;
  pix_t        meta_r;
  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [10:0] w, h;
  // Running quotient and remainder of row * TRI_SPACING / TRI_HEIGHT.
  logic [COORD_BITS-1:0] qt_r, qt_nxt;
  logic [8:0] rem_r, rem_nxt, rem_add;
  logic [COORD_BITS-1:0] half;
  logic row_end, frame_end;

  always_comb begin
    w = (width_cfg == 11'd0) ? 11'd1 : (width_cfg > 11'd1024 ? 11'd1024 : width_cfg);
    h = (height_cfg == 11'd0) ? 11'd1 : (height_cfg > 11'd1024 ? 11'd1024 : height_cfg);
    half = qt_r >> 1;
    rem_add = rem_r + 9'(TRI_SPACING);
    row_end = ({1'b0, col_r} + 11'd1) >= w;
    frame_end = row_end && (({1'b0, row_r} + 11'd1) >= h);
    col_nxt = col_r;
    row_nxt = row_r;
    qt_nxt = qt_r;
    rem_nxt = rem_r;
    if (in_fire && opcode) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        qt_nxt = '0;
        rem_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
        // The step is smaller than the divisor, so one subtraction suffices.
        if (rem_add >= 9'(TRI_HEIGHT)) begin
          rem_nxt = rem_add - 9'(TRI_HEIGHT);
          qt_nxt = qt_r + 1'b1;
        end else begin
          rem_nxt = rem_add;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !opcode) mem[{hue, saturation}] <= table_value;
    rd_r <= mem[{hue, saturation}];
    zero_r <= (hue == 8'hFF) || (saturation == 8'hFF);
    meta_r.col <= col_r;
    meta_r.half <= half;
    meta_r.active <= row_r >= first_row_cfg;
    meta_r.frame_end <= frame_end;
    meta_r.value <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      qt_r <= '0;
      rem_r <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      qt_r <= qt_nxt;
      rem_r <= rem_nxt;
      valid_r <= in_fire && opcode;
    end
  end

  always_comb begin
    pix = meta_r;
    pix.value = zero_r ? 8'd0 : rd_r;
    pix_valid = valid_r;
  end
endmodule

@@ rtl/pcts_fifo.sv @@
// Short queue of classified pixels between front and back parts.
// Depends on pcts_pkg.
module pcts_fifo import pcts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  pix_t wr_data,
  input  logic rd_en,
  output pix_t rd_data,
  output logic empty,
  output logic [FIFO_PTR_BITS:0] count
);
  pix_t buf_r [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_BITS-1:0] wp_r, rp_r;
  logic [FIFO_PTR_BITS:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_PTR_BITS+1)'(wr_en) - (FIFO_PTR_BITS+1)'(rd_en);
    end
  end

  assign rd_data = buf_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule

@@ rtl/pcts_div.sv @@
// Restoring divider, one quotient bit per cycle, for the score normalization.
// Depends on pcts_pkg.
module pcts_div import pcts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] q_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] shifted, diff;

  always_comb begin
    shifted = {rem_r[31:0], q_r[47]};
    diff = shifted - {1'b0, divisor};
  end

  // done stays high from the end of a division until the next start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
        done <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff;
        q_r <= {q_r[46:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r <= {q_r[46:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;
endmodule

@@ rtl/pcts_back.sv @@
// Back part: triangle accumulation, position count, scoring and the output word.
// Depends on pcts_pkg and pcts_div.
module pcts_back import pcts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  pix_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_user,
  output logic [23:0] out_data,
  output logic        out_last
);
  bk_state_t st_r, st_nxt;
  logic [SUM_BITS-1:0] sum_r [0:NUM_TRIANGLES-1];
  logic [POS_BITS-1:0] pos_r;
  logic [TRI_IDX_BITS-1:0] tri_r, tri_nxt;
  logic ov_r, kind_r, last_r;
  logic [7:0] pv_r;
  logic [15:0] sc_r;
  logic [TRI_IDX_BITS-1:0] idx_r;
  logic div_start, div_done;
  logic [47:0] quo;
  logic [31:0] denom;
  logic [15:0] score;
  logic out_free, take, emit_score;

  assign out_free = !ov_r || out_ready;
  assign denom = 32'(pos_r) * 32'd255;
  assign score = (denom == 32'd0) ? 16'd0 : ((|quo[47:16]) ? 16'hFFFF : quo[15:0]);

  pcts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({sum_r[tri_r], 16'd0}), .divisor(denom),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    st_nxt = st_r;
    tri_nxt = tri_r;
    take = 1'b0;
    div_start = 1'b0;
    emit_score = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          take = 1'b1;
          if (q_data.frame_end) begin
            st_nxt = BK_DIV;
            tri_nxt = '0;
          end
        end
      end
      BK_DIV: begin
        div_start = 1'b1;
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (div_done && out_free) begin
          emit_score = 1'b1;
          if (tri_r == TRI_IDX_BITS'(NUM_TRIANGLES - 1)) begin
            st_nxt = BK_IDLE;
          end else begin
            tri_nxt = tri_r + 1'b1;
            st_nxt = BK_DIV;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // A finished quotient waits in the divider until the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      tri_r <= '0;
      ov_r <= 1'b0;
      pos_r <= '0;
      for (int i = 0; i < NUM_TRIANGLES; i++) sum_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      tri_r <= tri_nxt;
      if (take || emit_score) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (take && q_data.active) begin
        for (int i = 0; i < NUM_TRIANGLES; i++) begin
          if ({1'b0, q_data.col} + {1'b0, q_data.half} >= 11'(i * TRI_SPACING) &&
              {1'b0, q_data.col} < 11'(i * TRI_SPACING) + {1'b0, q_data.half})
            sum_r[i] <= sum_r[i] + SUM_BITS'(q_data.value);
        end
        if (q_data.col == '0)
          pos_r <= pos_r + POS_BITS'({q_data.half, 1'b0});
      end
      if (emit_score && tri_r == TRI_IDX_BITS'(NUM_TRIANGLES - 1)) begin
        pos_r <= '0;
        for (int i = 0; i < NUM_TRIANGLES; i++) sum_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= 1'b0;
      pv_r <= q_data.value;
      idx_r <= '0;
      sc_r <= '0;
      last_r <= !q_data.frame_end;
    end else if (emit_score) begin
      kind_r <= 1'b1;
      pv_r <= '0;
      idx_r <= tri_r;
      sc_r <= score;
      last_r <= (tri_r == TRI_IDX_BITS'(NUM_TRIANGLES - 1));
    end
  end

  assign q_pop = take;
  assign out_valid = ov_r;
  assign out_user = {idx_r, kind_r};
  assign out_data = {sc_r, pv_r};
  assign out_last = last_r;
endmodule

@@ rtl/pixel_class_triangle_scorer.sv @@
// Top level of the pixel class triangle scorer.
// Depends on pcts_pkg, pcts_front, pcts_fifo and pcts_back.
//
// Table loads and pixels enter at one word per cycle while in_tready is high.
// Each pixel yields one preview word, which passes through the front part's
// read stage, the queue and the back part's output register. A pixel that
// ends a frame is followed by eleven score words, each produced by a 48-step
// shared divider; while they are produced, input stalls once the queue between
// front and back holds two words (room stays for the pixel in the front part's
// read stage). The class table is a 64K-entry memory with a registered read
// and is undefined until loaded.
module pixel_class_triangle_scorer import pcts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue[7:0], saturation[15:8], table_value[23:16]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // preview_value[7:0], score_fraction[23:8]
  output logic [4:0]  out_tuser,  // kind[0], triangle_index[4:1]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [10:0] width_r, height_r;
  logic [9:0]  first_row_r;
  logic in_fire, pix_valid, q_empty, q_pop;
  pix_t pix, q_data;
  logic [FIFO_PTR_BITS:0] q_count;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd640;
      height_r <= 11'd480;
      first_row_r <= 10'd50;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_WIDTH:     width_r <= cfg_pwdata[10:0];
        REG_HEIGHT:    height_r <= cfg_pwdata[10:0];
        REG_FIRST_ROW: first_row_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:     cfg_prdata = {21'd0, width_r};
      REG_HEIGHT:    cfg_prdata = {21'd0, height_r};
      REG_FIRST_ROW: cfg_prdata = {22'd0, first_row_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Room is kept for pixels already in the front part's read stage.
  assign in_tready = (q_count < (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));
  assign in_fire = in_tvalid && in_tready;

  pcts_front u_front (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .opcode(in_tuser),
    .hue(in_tdata[7:0]), .saturation(in_tdata[15:8]), .table_value(in_tdata[23:16]),
    .width_cfg(width_r), .height_cfg(height_r), .first_row_cfg(first_row_r),
    .pix_valid(pix_valid), .pix(pix)
  );

  pcts_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(pix_valid), .wr_data(pix),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty), .count(q_count)
  );

  pcts_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_user(out_tuser),
    .out_data(out_tdata), .out_last(out_tlast)
  );
endmodule
